// ===== design/sorted_table_binary_search_macros.svh =====
// Assertion macros used by the block that checks its own behavior.
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

`ifndef SYNTH

`define SBS_ASSERT_IMP(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed: same-cycle implication");

`define SBS_ASSERT_NXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed: next-cycle implication");

`else

`define SBS_ASSERT_IMP(label, clk, rst, cond, prop)

`define SBS_ASSERT_NXT(label, clk, rst, cond, prop)

`endif

`endif

// ===== design/sbs_pkg.sv =====
package sbs_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 16;
  localparam int WORD_W = 32;
  localparam int SLOT_W = 4;
  localparam int COUNT_W = 5;
  localparam int POS_W = 4;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CHECK
  } search_state_t;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic [POS_W-1:0] position;
  } result_t;

endpackage

// ===== design/sbs_ram.sv =====
module sbs_ram #(
  parameter int WIDTH = sbs_pkg::WORD_W,
  parameter int DEPTH = sbs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/sbs_search.sv =====
module sbs_search #(
  parameter int TABLE_DEPTH = sbs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              launch,
  input  logic signed [sbs_pkg::WORD_W-1:0] key_in,
  input  logic [sbs_pkg::COUNT_W-1:0]       count,
  output logic                              busy,
  output logic                              rd_en,
  output logic [$clog2(TABLE_DEPTH)-1:0]    rd_addr,
  input  logic [sbs_pkg::WORD_W-1:0]        rd_data,
  output sbs_pkg::result_t                  result
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int BW = $clog2(TABLE_DEPTH + 1);

  sbs_pkg::search_state_t state, state_next;
  logic [BW-1:0] lo, lo_next;
  logic [BW-1:0] hi, hi_next;
  logic [BW-1:0] mid, mid_next;
  logic signed [sbs_pkg::WORD_W-1:0] key, key_next;
  sbs_pkg::result_t result_next;

  logic [BW:0]   mid_sum;
  logic [BW-1:0] mid_calc;
  logic [BW-1:0] limit;
  logic [31:0]   mid_wide;
  logic signed [sbs_pkg::WORD_W-1:0] probe;

  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid_calc = mid_sum[BW:1];
  assign rd_addr  = mid_calc[AW-1:0];
  assign limit    = (32'(count) > 32'(TABLE_DEPTH)) ? BW'(TABLE_DEPTH) : BW'(count);
  assign mid_wide = 32'(mid);
  assign probe    = $signed(rd_data);
  assign busy     = (state != sbs_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= sbs_pkg::S_IDLE;
      result <= '0;
    end else begin
      state  <= state_next;
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    lo  <= lo_next;
    hi  <= hi_next;
    mid <= mid_next;
    key <= key_next;
  end

  always_comb begin
    state_next  = state;
    lo_next     = lo;
    hi_next     = hi;
    mid_next    = mid;
    key_next    = key;
    result_next = '0;
    rd_en       = 1'b0;
    unique case (state)
      sbs_pkg::S_IDLE: begin
        if (launch) begin
          key_next   = key_in;
          lo_next    = '0;
          hi_next    = limit;
          state_next = sbs_pkg::S_PROBE;
        end
      end
      sbs_pkg::S_PROBE: begin
        if (lo < hi) begin
          mid_next   = mid_calc;
          rd_en      = 1'b1;
          state_next = sbs_pkg::S_CHECK;
        end else begin
          result_next.valid = 1'b1;
          state_next        = sbs_pkg::S_IDLE;
        end
      end
      sbs_pkg::S_CHECK: begin
        if (probe == key) begin
          result_next.valid    = 1'b1;
          result_next.found    = 1'b1;
          result_next.position = mid_wide[sbs_pkg::POS_W-1:0];
          state_next           = sbs_pkg::S_IDLE;
        end else if (probe > key) begin
          hi_next    = mid;
          state_next = sbs_pkg::S_PROBE;
        end else begin
          lo_next    = mid + BW'(1);
          state_next = sbs_pkg::S_PROBE;
        end
      end
      default: begin
        state_next = sbs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/sorted_table_binary_search.sv =====
// Channel   Direction  Handshake               Payload
// request   in         start, busy             command, slot, word
// result    out        done (one-cycle strobe) found, position
// config    in         cfg_valid, cfg_ready    cfg_data (entry_count)
//
// A load request writes the table in the cycle it is accepted and gives no result.
// A search request makes P probes, where P is at most floor(log2(n)) + 1 for n entries in use;
// each probe reads the table in S_PROBE and compares the word in S_CHECK. A found key raises
// done from the compare; a miss raises done from S_PROBE once the search range is empty.
// Busy stays high until the cycle done is raised.
// Reset clears entry_count and the sequencer; table contents stay undefined until loaded.
// The result is driven for one cycle only and cannot be stalled.
`include "sorted_table_binary_search_macros.svh"

module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = sbs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              command,
  input  logic [sbs_pkg::SLOT_W-1:0]        slot,
  input  logic signed [sbs_pkg::WORD_W-1:0] word,
  output logic                              done,
  output logic                              found,
  output logic [sbs_pkg::POS_W-1:0]         position,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sbs_pkg::COUNT_W-1:0]       cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [sbs_pkg::COUNT_W-1:0] entry_count;
  logic                        accept;
  logic                        launch;
  logic                        wr_en;
  logic [31:0]                 slot_wide;
  logic [AW-1:0]               wr_addr;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [sbs_pkg::WORD_W-1:0]  rd_data;
  sbs_pkg::result_t            result;

  assign accept    = start && !busy;
  assign launch    = accept && (command == sbs_pkg::CMD_SEARCH);
  assign slot_wide = 32'(slot);
  assign wr_addr   = slot_wide[AW-1:0];
  assign wr_en     = accept && (command == sbs_pkg::CMD_LOAD) && (slot_wide < 32'(TABLE_DEPTH));
  assign cfg_ready = !busy;

  assign done     = result.valid;
  assign found    = result.found;
  assign position = result.position;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entry_count <= cfg_data;
    end
  end

  sbs_ram #(
    .WIDTH(sbs_pkg::WORD_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(word),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  sbs_search #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_search (
    .clk    (clk),
    .rst    (rst),
    .launch (launch),
    .key_in (word),
    .count  (entry_count),
    .busy   (busy),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .result (result)
  );

  `SBS_ASSERT_NXT(a_load_no_result, clk, rst, accept && (command == sbs_pkg::CMD_LOAD), !done)
  `SBS_ASSERT_NXT(a_search_goes_busy, clk, rst, launch, busy)
  `SBS_ASSERT_IMP(a_done_frees_block, clk, rst, done, !busy)
  `SBS_ASSERT_IMP(a_miss_position_zero, clk, rst, done && !found, position == '0)

endmodule
